FILE: design/sbpm_pkg.sv
// Shared constants, payload structs and control structs of the segmented buffer pool manager.
package sbpm_pkg;

  localparam int MaxSegments  = 8;
  localparam int MaxBufPerSeg = 16;
  localparam int SlotW        = $clog2(MaxSegments);
  localparam int PosW         = $clog2(MaxBufPerSeg);
  localparam int CntW         = $clog2(MaxBufPerSeg + 1);
  localparam int AddrW        = SlotW + PosW;
  localparam int Depth        = MaxSegments * MaxBufPerSeg;
  localparam int LenW         = $clog2(MaxSegments + 1);
  localparam int FreeW        = 8;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_FREE  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_BUF_PER_SEG = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_SEGS  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_MARK    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_MARK   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEL_LIMIT   = 3'd4;

  typedef struct packed {
    logic       op;
    logic [2:0] seg_slot;
    logic [3:0] buf_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] out_slot;
    logic [3:0] out_index;
    logic [7:0] free_buffers;
    logic [3:0] active_segments;
    logic       candidate_held;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic build;
    logic prep;
    logic read;
    logic alloc;
    logic free;
  } ctl_cmd_t;

  typedef struct packed {
    logic build_pending;
    logic op;
    logic out_free;
  } ctl_stat_t;

endpackage

FILE: design/sbpm_datapath.sv
// Pool state, free-index stack memory, segment list and result register.
module sbpm_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbpm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sbpm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  sbpm_pkg::in_item_t              in_item_i,
  input  sbpm_pkg::ctl_cmd_t              cmd_i,
  output sbpm_pkg::ctl_stat_t             stat_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sbpm_pkg::out_item_t             out_item_o
);

  localparam int NS = sbpm_pkg::MaxSegments;
  localparam int NB = sbpm_pkg::MaxBufPerSeg;
  localparam int SW = sbpm_pkg::SlotW;
  localparam int PW = sbpm_pkg::PosW;
  localparam int CW = sbpm_pkg::CntW;
  localparam int LW = sbpm_pkg::LenW;
  localparam int FW = sbpm_pkg::FreeW;

  logic [4:0] bps_q, bps_d, dlim_q, dlim_d;
  logic [3:0] start_q, start_d, low_q, low_d, high_q, high_d;
  logic       build_q, build_d;
  sbpm_pkg::in_item_t item_q, item_d;

  logic [NS-1:0]  active_q, active_d;
  logic [CW-1:0]  count_q [NS];
  logic [CW-1:0]  count_d [NS];
  logic [SW-1:0]  order_q [NS];
  logic [SW-1:0]  order_d [NS];
  logic [LW-1:0]  len_q, len_d;
  logic           cand_vld_q, cand_vld_d;
  logic [SW-1:0]  cand_slot_q, cand_slot_d;
  logic [FW-1:0]  ft_q, ft_d;
  logic [3:0]     seg_q, seg_d;
  logic           fail_q, fail_d;
  logic           rd_ok_q, rd_ok_d;
  logic [SW-1:0]  rd_slot_q, rd_slot_d;
  logic [PW-1:0]  rd_pos_q, rd_pos_d;
  logic           rd_vld_q, rd_vld_d;
  logic [PW-1:0]  rd_data_q;
  logic [sbpm_pkg::Depth-1:0] ent_vld_q, ent_vld_d;
  logic           out_valid_q, out_valid_d;
  sbpm_pkg::out_item_t out_q, out_d;

  logic [PW-1:0]  stack_mem [sbpm_pkg::Depth];
  logic           mem_we;
  logic [sbpm_pkg::AddrW-1:0] mem_waddr, mem_raddr;

  logic [CW-1:0]  n;
  logic [LW-1:0]  bcnt, last, btmp;
  logic [SW-1:0]  fslot, s, p;
  logic [CW-1:0]  cnt_s, pos_tmp;
  logic [FW-1:0]  ft1;
  logic           found, cv;
  logic [8:0]     bprod;

  // Out-of-range segment sizes are clamped.
  always_comb begin
    if (bps_q == '0) n = CW'(1);
    else if (bps_q > 5'(NB)) n = CW'(NB);
    else n = CW'(bps_q);
  end

  assign stat_o.build_pending = build_q;
  assign stat_o.op            = cmd_i.accept ? in_item_i.op : item_q.op;
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    bps_d = bps_q; start_d = start_q; low_d = low_q; high_d = high_q; dlim_d = dlim_q;
    build_d = build_q; item_d = item_q;
    active_d = active_q; count_d = count_q; order_d = order_q; len_d = len_q;
    cand_vld_d = cand_vld_q; cand_slot_d = cand_slot_q; ft_d = ft_q; seg_d = seg_q;
    fail_d = fail_q; rd_ok_d = rd_ok_q; rd_slot_d = rd_slot_q; rd_pos_d = rd_pos_q;
    rd_vld_d = rd_vld_q; ent_vld_d = ent_vld_q;
    out_valid_d = out_valid_q && !out_ready_i; out_d = out_q;
    mem_we = 1'b0; mem_waddr = '0;
    bcnt = '0; last = '0; btmp = '0; bprod = '0;
    fslot = '0; s = '0; p = '0; cnt_s = '0; pos_tmp = '0; ft1 = '0; found = 1'b0; cv = 1'b0;

    for (int i = NS - 1; i >= 0; i--) begin
      if (!active_q[i]) fslot = SW'(i);
    end

    if (cmd_i.accept) item_d = in_item_i;

    if (cmd_i.build) begin
      bcnt = (start_q > 4'(NS)) ? LW'(NS) : LW'(start_q);
      for (int i = 0; i < NS; i++) begin
        btmp = bcnt - LW'(i) - LW'(1);
        active_d[i] = LW'(i) < bcnt;
        count_d[i]  = (LW'(i) < bcnt) ? n : '0;
        order_d[i]  = (LW'(i) < bcnt) ? btmp[SW-1:0] : '0;
      end
      bprod = 9'(bcnt) * 9'(n);
      len_d = bcnt; ft_d = bprod[FW-1:0]; seg_d = 4'(bcnt);
      cand_vld_d = 1'b0; cand_slot_d = '0; ent_vld_d = '0; build_d = 1'b0;
    end

    if (cmd_i.prep) begin
      fail_d = 1'b0;
      if (ft_q == '0) begin
        if (seg_q >= high_q) begin
          fail_d = 1'b1;
        end else if (cand_vld_q || !(&active_q)) begin
          s = cand_vld_q ? cand_slot_q : fslot;
          if (!cand_vld_q) begin
            active_d[s] = 1'b1;
            count_d[s]  = n;
            for (int i = 0; i < NB; i++) ent_vld_d[{s, PW'(i)}] = 1'b0;
          end
          if (len_q < LW'(NS)) begin
            for (int j = NS - 1; j > 0; j--) order_d[j] = order_q[j-1];
            order_d[0] = s;
            len_d = len_q + LW'(1);
          end
          cand_vld_d = 1'b0;
          ft_d = ft_q + FW'(n);
          seg_d = seg_q + 4'd1;
        end else begin
          fail_d = 1'b1;
        end
      end
    end

    if (cmd_i.read) begin
      pos_tmp   = count_q[order_q[0]] - CW'(1);
      rd_slot_d = order_q[0];
      rd_pos_d  = pos_tmp[PW-1:0];
      rd_ok_d   = !fail_q && len_q != '0 && count_q[order_q[0]] != '0;
      rd_vld_d  = ent_vld_q[{order_q[0], pos_tmp[PW-1:0]}];
    end

    if (cmd_i.alloc) begin
      out_valid_d = 1'b1;
      out_d.out_slot = '0; out_d.out_index = '0;
      if (rd_ok_q) begin
        count_d[rd_slot_q] = CW'(rd_pos_q);
        out_d.status = sbpm_pkg::ST_OK;
        out_d.out_slot = rd_slot_q;
        // Entries not pushed since activation still hold their own position.
        out_d.out_index = rd_vld_q ? rd_data_q : rd_pos_q;
        if (rd_pos_q == '0) begin
          last = len_q - LW'(1);
          for (int j = 0; j < NS - 1; j++) order_d[j] = order_q[j+1];
          order_d[last[SW-1:0]] = rd_slot_q;
        end
        if (ft_q != '0) ft_d = ft_q - FW'(1);
      end else begin
        out_d.status = sbpm_pkg::ST_EXHAUSTED;
      end
    end

    if (cmd_i.free) begin
      out_valid_d = 1'b1;
      out_d.out_slot = '0; out_d.out_index = '0;
      s = item_q.seg_slot;
      cnt_s = count_q[s];
      if (!active_q[s] || cnt_s >= n) begin
        out_d.status = sbpm_pkg::ST_BAD_FREE;
      end else begin
        out_d.status = sbpm_pkg::ST_OK;
        mem_we = 1'b1;
        mem_waddr = {s, cnt_s[PW-1:0]};
        ent_vld_d[{s, cnt_s[PW-1:0]}] = 1'b1;
        count_d[s] = cnt_s + CW'(1);
        for (int j = NS - 1; j >= 0; j--) begin
          if (LW'(j) < len_q && order_q[j] == s) begin
            p = SW'(j); found = 1'b1;
          end
        end
        cv = cand_vld_q;
        if (cand_vld_q && ft_q > FW'(dlim_q)) begin
          active_d[cand_slot_q] = 1'b0;
          count_d[cand_slot_q]  = '0;
          cv = 1'b0;
        end
        ft1 = ft_q + FW'(1);
        if (cnt_s + CW'(1) == n && seg_q > low_q) begin
          // Fully free segment leaves the list.
          if (found) begin
            for (int j = 0; j < NS - 1; j++) begin
              if (SW'(j) >= p) order_d[j] = order_q[j+1];
            end
            len_d = len_q - LW'(1);
          end
          ft_d = (ft1 >= FW'(n)) ? ft1 - FW'(n) : '0;
          if (seg_q != '0) seg_d = seg_q - 4'd1;
          if (cv) begin
            active_d[s] = 1'b0;
            count_d[s]  = '0;
          end else begin
            cand_slot_d = s;
          end
          cand_vld_d = 1'b1;
        end else begin
          order_d[0] = s;
          for (int j = 1; j < NS; j++) begin
            if (!found || SW'(j) <= p) order_d[j] = order_q[j-1];
          end
          if (!found) len_d = len_q + LW'(1);
          ft_d = ft1;
          cand_vld_d = cv;
        end
      end
    end

    if (cmd_i.alloc || cmd_i.free) begin
      out_d.free_buffers = ft_d;
      out_d.active_segments = seg_d;
      out_d.candidate_held = cand_vld_d;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbpm_pkg::CFG_BUF_PER_SEG: begin bps_d = cfg_wdata_i; build_d = 1'b1; end
        sbpm_pkg::CFG_START_SEGS:  begin start_d = cfg_wdata_i[3:0]; build_d = 1'b1; end
        sbpm_pkg::CFG_LOW_MARK:    begin low_d = cfg_wdata_i[3:0]; build_d = 1'b1; end
        sbpm_pkg::CFG_HIGH_MARK:   begin high_d = cfg_wdata_i[3:0]; build_d = 1'b1; end
        sbpm_pkg::CFG_DEL_LIMIT:   begin dlim_d = cfg_wdata_i; build_d = 1'b1; end
        default: ;
      endcase
    end
  end

  assign mem_raddr = {order_q[0], pos_tmp[PW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_waddr] <= item_q.buf_index;
    if (cmd_i.read) rd_data_q <= stack_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q <= 5'd16; start_q <= 4'd1; low_q <= 4'd1; high_q <= 4'd8; dlim_q <= 5'd5;
      build_q <= 1'b1;
      active_q <= '0;
      for (int i = 0; i < NS; i++) begin
        count_q[i] <= '0;
        order_q[i] <= '0;
      end
      len_q <= '0; cand_vld_q <= 1'b0; cand_slot_q <= '0; ft_q <= '0; seg_q <= '0;
      fail_q <= 1'b0; rd_ok_q <= 1'b0; ent_vld_q <= '0; out_valid_q <= 1'b0;
    end else begin
      bps_q <= bps_d; start_q <= start_d; low_q <= low_d; high_q <= high_d; dlim_q <= dlim_d;
      build_q <= build_d;
      active_q <= active_d; count_q <= count_d; order_q <= order_d; len_q <= len_d;
      cand_vld_q <= cand_vld_d; cand_slot_q <= cand_slot_d; ft_q <= ft_d; seg_q <= seg_d;
      fail_q <= fail_d; rd_ok_q <= rd_ok_d; ent_vld_q <= ent_vld_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rd_slot_q <= rd_slot_d;
    rd_pos_q <= rd_pos_d;
    rd_vld_q <= rd_vld_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: design/sbpm_ctrl.sv
// Sequencing state machine of the buffer pool manager.
module sbpm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sbpm_pkg::ctl_stat_t  stat_i,
  output sbpm_pkg::ctl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {S_IDLE, S_BUILD, S_PREP, S_READ, S_ALLOC, S_FREE} state_e;
  state_e state_q;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == S_IDLE) && in_valid_i;
    cmd_o.build  = state_q == S_BUILD;
    cmd_o.prep   = state_q == S_PREP;
    cmd_o.read   = state_q == S_READ;
    cmd_o.alloc  = (state_q == S_ALLOC) && stat_i.out_free;
    cmd_o.free   = (state_q == S_FREE) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (stat_i.build_pending) state_q <= S_BUILD;
            else state_q <= (stat_i.op == sbpm_pkg::OP_FREE) ? S_FREE : S_PREP;
          end
        end
        S_BUILD: state_q <= (stat_i.op == sbpm_pkg::OP_FREE) ? S_FREE : S_PREP;
        S_PREP:  state_q <= S_READ;
        S_READ:  state_q <= S_ALLOC;
        S_ALLOC: if (stat_i.out_free) state_q <= S_IDLE;
        S_FREE:  if (stat_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/segmented_buffer_pool_manager_core.sv
// Top level of the segmented buffer pool manager.
// An allocate passes through the prepare, stack read (through the registered memory port) and
// update states before its result is registered; a free goes from acceptance to its update state.
// The first item after reset or after any write to a defined register first passes through a rebuild state.
// One item is in flight at a time; the next beat is accepted once the result is registered.
// Reset is asynchronous, active low, restores register defaults and schedules a rebuild.
module segmented_buffer_pool_manager_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sbpm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sbpm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sbpm_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sbpm_pkg::out_item_t            out_item_o
);

  sbpm_pkg::ctl_cmd_t  cmd;
  sbpm_pkg::ctl_stat_t stat;

  sbpm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .stat_i(stat), .cmd_o(cmd)
  );

  sbpm_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .in_item_i,
    .cmd_i(cmd), .stat_o(stat), .out_valid_o, .out_ready_i, .out_item_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second beat while an item was in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != sbpm_pkg::ST_OK |->
      out_item_o.out_slot == '0 && out_item_o.out_index == '0)
    else $error("failed request carries a buffer handle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.active_segments <= 4'(sbpm_pkg::MaxSegments)
      && out_item_o.status != 2'd3)
    else $error("result reports an impossible segment count or status");

endmodule

FILE: test/tb_segmented_buffer_pool_manager_core.sv
// Testbench for the segmented buffer pool manager: random and directed requests checked against a predictor.
module tb_segmented_buffer_pool_manager_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sbpm_pkg::*;

  // Scoreboard: models the pool and holds the handles it expects to see.
  class pool_scoreboard;
    int unsigned bufs_cfg, start_cfg, low_cfg, high_cfg, dlim_cfg;
    bit          active[MaxSegments];
    int unsigned fcount[MaxSegments];
    int unsigned stack[MaxSegments][MaxBufPerSeg];
    int unsigned order[$];
    bit          cand_valid;
    int unsigned cand_slot, free_tot, seg_tot;
    bit          rebuild_due;
    out_item_t   pending_results[$];
    int          errors;
    int unsigned live_handles[$];

    function new();
      bufs_cfg = 16; start_cfg = 1; low_cfg = 1; high_cfg = 8; dlim_cfg = 5;
      rebuild_due = 1;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
      case (idx)
        CFG_BUF_PER_SEG: bufs_cfg = val & 31;
        CFG_START_SEGS:  start_cfg = val & 15;
        CFG_LOW_MARK:    low_cfg = val & 15;
        CFG_HIGH_MARK:   high_cfg = val & 15;
        CFG_DEL_LIMIT:   dlim_cfg = val & 31;
        default: return;
      endcase
      rebuild_due = 1;
    endfunction

    function int unsigned seg_size();
      if (bufs_cfg == 0) return 1;
      if (bufs_cfg > MaxBufPerSeg) return MaxBufPerSeg;
      return bufs_cfg;
    endfunction

    function void unlist(int unsigned s);
      foreach (order[i]) if (order[i] == s) begin
        order.delete(i);
        return;
      end
    endfunction

    function bit activate();
      int unsigned n;
      n = seg_size();
      for (int s = 0; s < MaxSegments; s++) if (!active[s]) begin
        active[s] = 1;
        for (int i = 0; i < n; i++) stack[s][i] = i;
        fcount[s] = n;
        order.push_front(s);
        free_tot += n;
        seg_tot++;
        return 1;
      end
      return 0;
    endfunction

    function void note_request(in_item_t it);
      out_item_t   r;
      int unsigned n, s, cnt;
      bit          ok;
      if (rebuild_due) begin
        foreach (active[i]) begin
          active[i] = 0;
          fcount[i] = 0;
        end
        order = {};
        cand_valid = 0; cand_slot = 0; free_tot = 0; seg_tot = 0;
        live_handles = {};
        cnt = (start_cfg > MaxSegments) ? MaxSegments : start_cfg;
        for (int k = 0; k < cnt; k++) void'(activate());
        rebuild_due = 0;
      end
      n = seg_size();
      r = '0;
      if (it.op == OP_ALLOC) begin
        ok = 1;
        if (free_tot == 0) begin
          if (seg_tot >= high_cfg) ok = 0;
          else if (cand_valid) begin
            order.push_front(cand_slot);
            cand_valid = 0;
            free_tot += n;
            seg_tot++;
          end else if (!activate()) ok = 0;
        end
        if (ok && (order.size() == 0 || fcount[order[0]] == 0)) ok = 0;
        if (ok) begin
          s = order[0];
          fcount[s]--;
          r.out_slot = 3'(s);
          r.out_index = 4'(stack[s][fcount[s]]);
          live_handles.push_back(s * 16 + r.out_index);
          if (fcount[s] == 0) begin
            unlist(s);
            order.push_back(s);
          end
          if (free_tot > 0) free_tot--;
        end else r.status = ST_EXHAUSTED;
      end else begin
        s = it.seg_slot;
        if (!active[s] || fcount[s] >= n) r.status = ST_BAD_FREE;
        else begin
          stack[s][fcount[s]] = it.buf_index;
          fcount[s]++;
          foreach (live_handles[i]) if (live_handles[i] == s * 16 + it.buf_index) begin
            live_handles.delete(i);
            break;
          end
          unlist(s);
          order.push_front(s);
          if (cand_valid && free_tot > dlim_cfg) begin
            active[cand_slot] = 0;
            fcount[cand_slot] = 0;
            cand_valid = 0;
          end
          free_tot++;
          if (fcount[s] == n && seg_tot > low_cfg) begin
            unlist(s);
            free_tot = (free_tot >= n) ? free_tot - n : 0;
            if (seg_tot > 0) seg_tot--;
            if (cand_valid) begin
              active[s] = 0;
              fcount[s] = 0;
            end else begin
              cand_valid = 1;
              cand_slot = s;
            end
          end
        end
      end
      r.free_buffers = 8'(free_tot);
      r.active_segments = 4'(seg_tot);
      r.candidate_held = cand_valid;
      pending_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %p", got);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.out_slot !== e.out_slot) begin
        $error("out_slot exp %0d got %0d", e.out_slot, got.out_slot); errors++;
      end
      if (got.out_index !== e.out_index) begin
        $error("out_index exp %0d got %0d", e.out_index, got.out_index); errors++;
      end
      if (got.free_buffers !== e.free_buffers) begin
        $error("free_buffers exp %0d got %0d", e.free_buffers, got.free_buffers); errors++;
      end
      if (got.active_segments !== e.active_segments) begin
        $error("active_segments exp %0d got %0d", e.active_segments, got.active_segments);
        errors++;
      end
      if (got.candidate_held !== e.candidate_held) begin
        $error("candidate_held exp %0d got %0d", e.candidate_held, got.candidate_held);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic               in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_item_t           in_item_i;
  out_item_t          out_item_o;

  pool_scoreboard pool_sb;
  int unsigned    idle_cycles;
  bit             rx_stall_on;

  segmented_buffer_pool_manager_core u_dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: random stalls, check every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) pool_sb.check_result(out_item_o);
      out_ready_i <= rx_stall_on ? ($urandom_range(3) == 0) : 1'b1;
    end
  end

  // Watchdog: cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb_segmented_buffer_pool_manager_core failed");
      $finish;
    end
  end

  // Valid stays high after a beat only when the next beat follows with no gap.
  task automatic send_item(in_item_t it);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pool_sb.note_request(it);
  endtask

  task automatic send_alloc();
    in_item_t it;
    it = {OP_ALLOC, 3'($urandom), 4'($urandom)};
    send_item(it);
  endtask

  task automatic send_free(logic [2:0] s, logic [3:0] b);
    in_item_t it;
    it.op = OP_FREE; it.seg_slot = s; it.buf_index = b;
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pool_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgDataW'(val);
    @(posedge clk_i);
    pool_sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // About half allocations, the rest mostly frees of handles still out, so segments refill and get released.
  task automatic random_traffic(int unsigned count);
    int unsigned k, h, p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      if (p < 8) send_free(3'($urandom), 4'($urandom));
      else if (p < 50 && pool_sb.live_handles.size() != 0) begin
        k = $urandom_range(pool_sb.live_handles.size() - 1);
        h = pool_sb.live_handles[k];
        send_free(3'(h / 16), 4'(h % 16));
      end else send_alloc();
    end
  endtask

  initial begin
    pool_sb     = new();
    rst_ni      = 0;
    cfg_we_i    = 0;
    cfg_idx_i   = CFG_BUF_PER_SEG;
    cfg_wdata_i = '0;
    in_valid_i  = 0;
    in_item_i   = '0;
    out_ready_i = 0;
    idle_cycles = 0;
    rx_stall_on = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: default pool, use up the first segment so a second is activated, a bad free, frees into segment 0.
    for (int i = 0; i < 17; i++) send_alloc();
    send_free(3'd7, 4'd15);
    send_free(3'd0, 4'd0);
    send_free(3'd0, 4'd15);
    send_alloc();
    drain();

    // Extreme settings: zero and oversized segment sizes, zero start count.
    write_cfg(CFG_BUF_PER_SEG, 0);
    write_cfg(CFG_START_SEGS, 0);
    write_cfg(CFG_LOW_MARK, 0);
    write_cfg(CFG_HIGH_MARK, 8);
    write_cfg(CFG_DEL_LIMIT, 0);
    rx_stall_on = 1;
    random_traffic(60);
    drain();
    write_cfg(CFG_BUF_PER_SEG, 31);
    write_cfg(CFG_START_SEGS, 15);
    write_cfg(CFG_DEL_LIMIT, 31);
    random_traffic(60);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_cfg(CFG_BUF_PER_SEG, $urandom_range(1, 6));
      write_cfg(CFG_START_SEGS, $urandom_range(0, 8));
      write_cfg(CFG_LOW_MARK, $urandom_range(0, 8));
      write_cfg(CFG_HIGH_MARK, $urandom_range(1, 8));
      write_cfg(CFG_DEL_LIMIT, $urandom_range(0, 16));
      rx_stall_on = (ph % 3) != 0;
      random_traffic(95);
    end
    drain();

    if (pool_sb.errors == 0 && pool_sb.pending_results.size() == 0)
      $display("tb_segmented_buffer_pool_manager_core passed");
    else
      $display("tb_segmented_buffer_pool_manager_core failed");
    $finish;
  end
endmodule
